### design/sqvg_pkg.sv
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared constants for the sprite quad vertex generator and its checker.
// ----------------------------------------------------------------------------
package sqvg_pkg;

    localparam int VERTS_PER_SPRITE = 6;
    localparam int VERT_IDX_W       = $clog2(VERTS_PER_SPRITE);
    localparam logic [VERT_IDX_W-1:0] LAST_VERT = VERT_IDX_W'(VERTS_PER_SPRITE - 1);
    localparam logic [VERT_IDX_W-1:0] REPEAT_VERT = VERT_IDX_W'(3);

    // corner 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
    localparam logic [1:0] CORNER_OF_VERTEX [VERTS_PER_SPRITE] =
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

    localparam int POS_W   = 24;
    localparam int SCALE_W = 16;
    localparam int TRIG_W  = 16;
    localparam int OFF_W   = 25;
    localparam int LOC_W   = OFF_W + SCALE_W;
    localparam int PROD_W  = LOC_W + TRIG_W;
    localparam int ROT_W   = PROD_W + 2;
    localparam int RND_SH  = 22;
    localparam int SHR_W   = ROT_W - RND_SH;
    localparam int SUM_W   = SHR_W + 1;
    localparam int VTX_W   = 32;
    localparam int TEX_W   = 15;

    localparam logic [TEX_W-1:0] TEX_MAX = {TEX_W{1'b1}};

endpackage

### design/sprite_quad_vertex_gen.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_gen
// Turns one sprite into six vertices of two triangles, fixed-point transform.
// ----------------------------------------------------------------------------
// A sprite is held while its six vertices (p0,p1,p2,p0,p2,p3) are issued one
// per cycle, barring stalls, into a four-stage pipeline: local offset times
// scale, rotation products, rounded rotation sums, position add with
// saturation. The next sprite is taken in the cycle its predecessor issues
// its sixth vertex. An accepted sprite is registered in the hold register,
// then each vertex passes stage registers 1 to 4 to the output. Back-pressure
// on the result channel stalls the pipeline without loss.
module sprite_quad_vertex_gen (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sqvg_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [sqvg_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [sqvg_pkg::POS_W-1:0]     s_origin_x,
    input  logic signed [sqvg_pkg::POS_W-1:0]     s_origin_y,
    input  logic signed [sqvg_pkg::SCALE_W-1:0]   s_scale_x,
    input  logic signed [sqvg_pkg::SCALE_W-1:0]   s_scale_y,
    input  logic [13:0]                           s_rect_left,
    input  logic [13:0]                           s_rect_top,
    input  logic [14:0]                           s_rect_width,
    input  logic [14:0]                           s_rect_height,
    input  logic signed [sqvg_pkg::TRIG_W-1:0]    s_sine_value,
    input  logic signed [sqvg_pkg::TRIG_W-1:0]    s_cosine_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sqvg_pkg::VTX_W-1:0]     m_vertex_x,
    output logic signed [sqvg_pkg::VTX_W-1:0]     m_vertex_y,
    output logic [sqvg_pkg::TEX_W-1:0]            m_tex_u,
    output logic [sqvg_pkg::TEX_W-1:0]            m_tex_v,
    output logic                                  m_last_vertex
);

    typedef struct packed {
        logic signed [sqvg_pkg::POS_W-1:0]   pos_x;
        logic signed [sqvg_pkg::POS_W-1:0]   pos_y;
        logic signed [sqvg_pkg::POS_W-1:0]   origin_x;
        logic signed [sqvg_pkg::POS_W-1:0]   origin_y;
        logic signed [sqvg_pkg::SCALE_W-1:0] scale_x;
        logic signed [sqvg_pkg::SCALE_W-1:0] scale_y;
        logic [13:0]                         left;
        logic [13:0]                         top;
        logic [14:0]                         width;
        logic [14:0]                         height;
        logic signed [sqvg_pkg::TRIG_W-1:0]  sine;
        logic signed [sqvg_pkg::TRIG_W-1:0]  cosine;
    } sprite_t;

    typedef struct packed {
        logic signed [sqvg_pkg::POS_W-1:0] pos_x;
        logic signed [sqvg_pkg::POS_W-1:0] pos_y;
        logic [sqvg_pkg::TEX_W-1:0]        u;
        logic [sqvg_pkg::TEX_W-1:0]        v;
        logic                              last;
    } pass_t;

    typedef struct packed {
        pass_t                               pass;
        logic signed [sqvg_pkg::LOC_W-1:0]   lx;
        logic signed [sqvg_pkg::LOC_W-1:0]   ly;
        logic signed [sqvg_pkg::TRIG_W-1:0]  sine;
        logic signed [sqvg_pkg::TRIG_W-1:0]  cosine;
    } st1_t;

    typedef struct packed {
        pass_t                               pass;
        logic signed [sqvg_pkg::PROD_W-1:0]  lx_cos;
        logic signed [sqvg_pkg::PROD_W-1:0]  ly_sin;
        logic signed [sqvg_pkg::PROD_W-1:0]  lx_sin;
        logic signed [sqvg_pkg::PROD_W-1:0]  ly_cos;
    } st2_t;

    typedef struct packed {
        pass_t                               pass;
        logic signed [sqvg_pkg::ROT_W-1:0]   rx;
        logic signed [sqvg_pkg::ROT_W-1:0]   ry;
    } st3_t;

    typedef struct packed {
        logic signed [sqvg_pkg::VTX_W-1:0] x;
        logic signed [sqvg_pkg::VTX_W-1:0] y;
        logic [sqvg_pkg::TEX_W-1:0]        u;
        logic [sqvg_pkg::TEX_W-1:0]        v;
        logic                              last;
    } st4_t;

    localparam logic signed [sqvg_pkg::ROT_W-1:0] ROUND_HALF =
        sqvg_pkg::ROT_W'(1) <<< (sqvg_pkg::RND_SH - 1);

    function automatic logic signed [sqvg_pkg::VTX_W-1:0] sat_vtx(
        input logic signed [sqvg_pkg::SUM_W-1:0] val
    );
        logic hi_same;
        logic hi_zero;
        hi_same = &val[sqvg_pkg::SUM_W-1:sqvg_pkg::VTX_W-1];
        hi_zero = ~|val[sqvg_pkg::SUM_W-1:sqvg_pkg::VTX_W-1];
        if (hi_same || hi_zero) begin
            return val[sqvg_pkg::VTX_W-1:0];
        end else if (val[sqvg_pkg::SUM_W-1]) begin
            return {1'b1, {(sqvg_pkg::VTX_W-1){1'b0}}};
        end else begin
            return {1'b0, {(sqvg_pkg::VTX_W-1){1'b1}}};
        end
    endfunction

    // sprite hold and vertex sequencer
    sprite_t                         spr_reg, spr_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [sqvg_pkg::VERT_IDX_W-1:0] vert_reg, vert_next;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;

    logic rdy1, rdy2, rdy3, rdy4;
    logic issue;
    logic in_fire;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign issue   = hold_valid_reg && rdy1;
    assign s_ready = !hold_valid_reg || (rdy1 && vert_reg == sqvg_pkg::LAST_VERT);
    assign in_fire = s_valid && s_ready;

    always_comb begin
        spr_next        = spr_reg;
        hold_valid_next = hold_valid_reg;
        vert_next       = vert_reg;
        if (in_fire) begin
            spr_next.pos_x    = s_pos_x;
            spr_next.pos_y    = s_pos_y;
            spr_next.origin_x = s_origin_x;
            spr_next.origin_y = s_origin_y;
            spr_next.scale_x  = s_scale_x;
            spr_next.scale_y  = s_scale_y;
            spr_next.left     = s_rect_left;
            spr_next.top      = s_rect_top;
            spr_next.width    = s_rect_width;
            spr_next.height   = s_rect_height;
            spr_next.sine     = s_sine_value;
            spr_next.cosine   = s_cosine_value;
            hold_valid_next   = 1'b1;
            vert_next         = '0;
        end else if (issue && vert_reg == sqvg_pkg::LAST_VERT) begin
            hold_valid_next = 1'b0;
        end else if (issue) begin
            vert_next = vert_reg + 1'b1;
        end
    end

    // stage 1: local offset times scale, texture coordinates
    logic [1:0]                         corner;
    logic                               right;
    logic                               bottom;
    logic signed [sqvg_pkg::OFF_W-1:0]  off_x;
    logic signed [sqvg_pkg::OFF_W-1:0]  off_y;
    logic [sqvg_pkg::TEX_W:0]           u_sum;
    logic [sqvg_pkg::TEX_W:0]           v_sum;
    logic [sqvg_pkg::TEX_W-1:0]         u_far;
    logic [sqvg_pkg::TEX_W-1:0]         v_far;

    always_comb begin
        corner = sqvg_pkg::CORNER_OF_VERTEX[vert_reg];
        right  = (corner == 2'd1) || (corner == 2'd2);
        bottom = corner[1];
        off_x  = (right ? {2'b00, spr_reg.width, 8'h00} : '0)
                 - {spr_reg.origin_x[sqvg_pkg::POS_W-1], spr_reg.origin_x};
        off_y  = (bottom ? {2'b00, spr_reg.height, 8'h00} : '0)
                 - {spr_reg.origin_y[sqvg_pkg::POS_W-1], spr_reg.origin_y};
        u_sum  = {2'b00, spr_reg.left} + {1'b0, spr_reg.width};
        v_sum  = {2'b00, spr_reg.top} + {1'b0, spr_reg.height};
        u_far  = u_sum[sqvg_pkg::TEX_W] ? sqvg_pkg::TEX_MAX : u_sum[sqvg_pkg::TEX_W-1:0];
        v_far  = v_sum[sqvg_pkg::TEX_W] ? sqvg_pkg::TEX_MAX : v_sum[sqvg_pkg::TEX_W-1:0];

        st1_next            = st1_reg;
        v1_next             = v1_reg;
        if (rdy1) begin
            v1_next = issue;
            if (issue) begin
                st1_next.lx          = off_x * spr_reg.scale_x;
                st1_next.ly          = off_y * spr_reg.scale_y;
                st1_next.sine        = spr_reg.sine;
                st1_next.cosine      = spr_reg.cosine;
                st1_next.pass.pos_x  = spr_reg.pos_x;
                st1_next.pass.pos_y  = spr_reg.pos_y;
                st1_next.pass.u      = right ? u_far : {1'b0, spr_reg.left};
                st1_next.pass.v      = bottom ? v_far : {1'b0, spr_reg.top};
                st1_next.pass.last   = (vert_reg == sqvg_pkg::LAST_VERT);
            end
        end
    end

    // stage 2: rotation products
    always_comb begin
        st2_next = st2_reg;
        v2_next  = v2_reg;
        if (rdy2) begin
            v2_next = v1_reg;
            if (v1_reg) begin
                st2_next.pass   = st1_reg.pass;
                st2_next.lx_cos = st1_reg.lx * st1_reg.cosine;
                st2_next.ly_sin = st1_reg.ly * st1_reg.sine;
                st2_next.lx_sin = st1_reg.lx * st1_reg.sine;
                st2_next.ly_cos = st1_reg.ly * st1_reg.cosine;
            end
        end
    end

    // stage 3: rotated sums with half-up rounding bias
    always_comb begin
        st3_next = st3_reg;
        v3_next  = v3_reg;
        if (rdy3) begin
            v3_next = v2_reg;
            if (v2_reg) begin
                st3_next.pass = st2_reg.pass;
                st3_next.rx   = {{2{st2_reg.lx_cos[sqvg_pkg::PROD_W-1]}}, st2_reg.lx_cos}
                              - {{2{st2_reg.ly_sin[sqvg_pkg::PROD_W-1]}}, st2_reg.ly_sin}
                              + ROUND_HALF;
                st3_next.ry   = {{2{st2_reg.lx_sin[sqvg_pkg::PROD_W-1]}}, st2_reg.lx_sin}
                              + {{2{st2_reg.ly_cos[sqvg_pkg::PROD_W-1]}}, st2_reg.ly_cos}
                              + ROUND_HALF;
            end
        end
    end

    // stage 4: floor shift, position add, saturation
    logic signed [sqvg_pkg::SUM_W-1:0] sum_x;
    logic signed [sqvg_pkg::SUM_W-1:0] sum_y;

    always_comb begin
        sum_x = {st3_reg.rx[sqvg_pkg::ROT_W-1], st3_reg.rx[sqvg_pkg::ROT_W-1:sqvg_pkg::RND_SH]}
              + {{(sqvg_pkg::SUM_W-sqvg_pkg::POS_W){st3_reg.pass.pos_x[sqvg_pkg::POS_W-1]}},
                 st3_reg.pass.pos_x};
        sum_y = {st3_reg.ry[sqvg_pkg::ROT_W-1], st3_reg.ry[sqvg_pkg::ROT_W-1:sqvg_pkg::RND_SH]}
              + {{(sqvg_pkg::SUM_W-sqvg_pkg::POS_W){st3_reg.pass.pos_y[sqvg_pkg::POS_W-1]}},
                 st3_reg.pass.pos_y};
        st4_next = st4_reg;
        v4_next  = v4_reg;
        if (rdy4) begin
            v4_next = v3_reg;
            if (v3_reg) begin
                st4_next.x    = sat_vtx(sum_x);
                st4_next.y    = sat_vtx(sum_y);
                st4_next.u    = st3_reg.pass.u;
                st4_next.v    = st3_reg.pass.v;
                st4_next.last = st3_reg.pass.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            vert_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            vert_reg       <= vert_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            v3_reg         <= v3_next;
            v4_reg         <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        spr_reg <= spr_next;
        st1_reg <= st1_next;
        st2_reg <= st2_next;
        st3_reg <= st3_next;
        st4_reg <= st4_next;
    end

    assign m_valid       = v4_reg;
    assign m_vertex_x    = st4_reg.x;
    assign m_vertex_y    = st4_reg.y;
    assign m_tex_u       = st4_reg.u;
    assign m_tex_v       = st4_reg.v;
    assign m_last_vertex = st4_reg.last;

endmodule

### design/sqvg_checker.sv
// ----------------------------------------------------------------------------
// sqvg_checker
// Port-level checks on the sprite quad vertex generator, bound to the top.
// ----------------------------------------------------------------------------
module sqvg_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [sqvg_pkg::VTX_W-1:0] m_vertex_x,
    input logic signed [sqvg_pkg::VTX_W-1:0] m_vertex_y,
    input logic                              m_last_vertex
);

    logic [sqvg_pkg::VERT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [4:0]                      pending_reg, pending_next;
    logic signed [sqvg_pkg::VTX_W-1:0] first_x_reg, first_x_next;
    logic in_fire;
    logic out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    always_comb begin
        out_idx_next = out_idx_reg;
        first_x_next = first_x_reg;
        if (out_fire) begin
            out_idx_next = (out_idx_reg == sqvg_pkg::LAST_VERT) ? '0 : out_idx_reg + 1'b1;
            if (out_idx_reg == '0) begin
                first_x_next = m_vertex_x;
            end
        end
        pending_next = pending_reg
                     + (in_fire ? 5'(sqvg_pkg::VERTS_PER_SPRITE) : 5'd0)
                     - (out_fire ? 5'd1 : 5'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_idx_reg <= '0;
            pending_reg <= '0;
        end else begin
            out_idx_reg <= out_idx_next;
            pending_reg <= pending_next;
        end
        first_x_reg <= first_x_next;
    end

    // last flag only on the sixth transaction of each sprite
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |-> (m_last_vertex == (out_idx_reg == sqvg_pkg::LAST_VERT)))
        else $error("last_vertex out of place");

    // no vertex without an accepted sprite behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 5'd0))
        else $error("vertex with no sprite pending");

    // fourth vertex repeats corner p0 (x coordinate checked)
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && out_idx_reg == sqvg_pkg::REPEAT_VERT) |-> (m_vertex_x == first_x_reg))
        else $error("p0 repeat mismatch");

    // stalled output holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_vertex_x) && $stable(m_vertex_y)))
        else $error("output changed under stall");

endmodule

bind sprite_quad_vertex_gen sqvg_checker u_sqvg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_vertex_x    (m_vertex_x),
    .m_vertex_y    (m_vertex_y),
    .m_last_vertex (m_last_vertex)
);
